>>> rtl/core/assert_macros.svh
// assertion macros used by the qualified event logger
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define QEL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qualified event logger: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define QEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qualified event logger: next-cycle check failed");

`endif

>>> rtl/core/qel_pkg.sv
// types and codes of the qualified event logger
package qel_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD   = 2'd1;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned TUSER_W     = 2;
    localparam int unsigned FIELD_TIME_W = 32;

    // per-channel qualifier status
    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_HOLD_START = 2'd1,
        ST_ACTIVE     = 2'd2,
        ST_HOLD_END   = 2'd3
    } chan_status_t;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UPD  = 7'b0000010,
        S_UPD2 = 7'b0000100,
        S_RADR = 7'b0001000,
        S_RDAT = 7'b0010000,
        S_CLR  = 7'b0100000,
        S_WAIT = 7'b1000000
    } seq_state_t;

endpackage

>>> rtl/core/qualified_event_logger.sv
// qualified event logger: six sag/swell qualifiers with per-channel timestamp rings
//
// Input items arrive on s_t* (kind in s_tuser: flag update, log read or clear);
// each item gives exactly one result item on m_t*.
// An update walks the six channels one per cycle through the channel state;
// a channel that logs an end also passes through S_UPD2 to zero its next ring entry.
// A clear sweeps the timestamp memories one entry a cycle, as set by the single
// write port of each timestamp memory. After reset the same sweep runs before
// s_tready rises; configuration writes are taken throughout.
// The result sits in an output register: the next item is accepted and
// worked on while it waits, and only the hand-over to the output register
// waits for m_tready when the receiver stalls.
module qualified_event_logger #(
    parameter int LOG_DEPTH    = 8,
    parameter int NUM_CHANNELS = 6,
    parameter int TIME_BITS    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qel_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [7:0]                           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // sag_flags, swell_flags, dir_flags, timestamp, channel, offset
    input  logic [qel_pkg::IN_TDATA_W-1:0]       s_tdata,
    // req_type
    input  logic [qel_pkg::TUSER_W-1:0]          s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // event_count, start_time, end_time, last_flags
    output logic [qel_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // req_ok, log_changed
    output logic [qel_pkg::TUSER_W-1:0]          m_tuser
);

    localparam int DEPTH_ALL = NUM_CHANNELS * LOG_DEPTH;
    localparam int AW = $clog2(DEPTH_ALL);
    localparam int IW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(NUM_CHANNELS);

    // configuration
    logic [7:0] start_hold_reg;
    logic [7:0] end_hold_reg;

    // latched item
    logic [5:0]           bits_reg;
    logic [TIME_BITS-1:0] ts_reg;
    logic [2:0]           ch_reg;
    logic [7:0]           off_reg;
    logic [13:0]          flag_copy_reg;

    // sequencer
    qel_pkg::seq_state_t state_reg;
    logic [CW-1:0]       cnt_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                clr_reply_reg;
    logic                changed_reg;

    // pending result
    logic                 res_ok_reg;
    logic                 res_changed_reg;
    logic [7:0]           res_count_reg;
    logic [TIME_BITS-1:0] res_start_reg;
    logic [TIME_BITS-1:0] res_end_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [qel_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic [qel_pkg::TUSER_W-1:0]   m_tuser_reg;

    // channel state
    qel_pkg::chan_status_t status_reg [NUM_CHANNELS];
    logic [7:0]            hold_reg   [NUM_CHANNELS];
    logic [IW-1:0]         wi_reg     [NUM_CHANNELS];
    logic [7:0]            done_reg   [NUM_CHANNELS];

    // timestamp memories
    logic [TIME_BITS-1:0] st_mem [DEPTH_ALL];
    logic [TIME_BITS-1:0] en_mem [DEPTH_ALL];
    logic [TIME_BITS-1:0] st_rd_reg;
    logic [TIME_BITS-1:0] en_rd_reg;

    logic                  accept;
    logic                  out_free;
    logic [CW-1:0]         sel_ch;
    qel_pkg::chan_status_t cur_status;
    logic [7:0]            cur_hold;
    logic [IW-1:0]         cur_wi;
    logic [7:0]            cur_done;
    logic [7:0]            hold_dec;
    logic                  flag;
    logic [AW-1:0]         base_addr;
    qel_pkg::chan_status_t status_next;
    logic [7:0]            hold_next;
    logic [IW-1:0]         wi_next;
    logic [7:0]            done_next;
    logic                  ended;
    logic                  upd_st_we;
    logic                  upd_en_we;
    logic [TIME_BITS-1:0]  upd_st_wd;
    logic [TIME_BITS-1:0]  upd_en_wd;
    logic                  st_we;
    logic                  en_we;
    logic [AW-1:0]         waddr;
    logic [TIME_BITS-1:0]  st_wd;
    logic [TIME_BITS-1:0]  en_wd;
    logic                  ch_ok;
    logic                  off_ok;
    logic [IW-1:0]         off_low;
    logic [IW:0]           rd_sum;
    logic [IW-1:0]         rd_idx;
    logic [AW-1:0]         raddr;
    logic                  mem_re;
    logic                  clr_all;
    logic                  last_ch;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == qel_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // one channel-state read address, shared between update walk and read
    assign sel_ch = (state_reg == qel_pkg::S_UPD || state_reg == qel_pkg::S_UPD2) ?
                    cnt_reg : ch_reg[CW-1:0];
    assign cur_status = status_reg[sel_ch];
    assign cur_hold   = hold_reg[sel_ch];
    assign cur_wi     = wi_reg[sel_ch];
    assign cur_done   = done_reg[sel_ch];
    assign hold_dec   = cur_hold - 8'd1;
    assign flag       = bits_reg[cnt_reg];
    assign base_addr  = AW'(AW'(sel_ch) * AW'(LOG_DEPTH));
    assign last_ch    = (cnt_reg == CW'(NUM_CHANNELS - 1));

    // qualifier step of the channel under the walk
    always_comb
    begin
        status_next = cur_status;
        hold_next   = cur_hold;
        wi_next     = cur_wi;
        done_next   = cur_done;
        ended       = 1'b0;
        upd_st_we   = 1'b0;
        upd_en_we   = 1'b0;
        upd_st_wd   = '0;
        upd_en_wd   = '0;
        unique case (cur_status)
            qel_pkg::ST_IDLE:
            begin
                if (flag)
                begin
                    status_next = qel_pkg::ST_HOLD_START;
                    hold_next   = start_hold_reg;
                end
            end
            qel_pkg::ST_HOLD_START:
            begin
                if (flag)
                begin
                    hold_next = hold_dec;
                    if (hold_dec == 8'd0)
                    begin
                        status_next = qel_pkg::ST_ACTIVE;
                        upd_st_we   = 1'b1;
                        upd_en_we   = 1'b1;
                        upd_st_wd   = ts_reg;
                    end
                end
                else
                begin
                    // start hold cancelled: drop the start time
                    status_next = qel_pkg::ST_IDLE;
                    upd_st_we   = 1'b1;
                end
            end
            qel_pkg::ST_ACTIVE:
            begin
                if (!flag)
                begin
                    status_next = qel_pkg::ST_HOLD_END;
                    hold_next   = end_hold_reg;
                end
            end
            qel_pkg::ST_HOLD_END:
            begin
                if (!flag)
                begin
                    hold_next = hold_dec;
                    if (hold_dec == 8'd0)
                    begin
                        status_next = qel_pkg::ST_IDLE;
                        upd_en_we   = 1'b1;
                        upd_en_wd   = ts_reg;
                        wi_next     = (cur_wi == IW'(LOG_DEPTH - 1)) ? '0 : cur_wi + IW'(1);
                        done_next   = cur_done + 8'd1;
                        ended       = 1'b1;
                    end
                end
                else
                begin
                    status_next = qel_pkg::ST_ACTIVE;
                end
            end
            default:
            begin
                status_next = cur_status;
            end
        endcase
    end

    // memory write port mux
    always_comb
    begin
        st_we = 1'b0;
        en_we = 1'b0;
        waddr = base_addr + AW'(cur_wi);
        st_wd = '0;
        en_wd = '0;
        unique case (state_reg)
            qel_pkg::S_UPD:
            begin
                st_we = upd_st_we;
                en_we = upd_en_we;
                st_wd = upd_st_wd;
                en_wd = upd_en_wd;
            end
            qel_pkg::S_UPD2:
            begin
                // index already advanced: zero the entry it now points at
                st_we = 1'b1;
                en_we = 1'b1;
            end
            qel_pkg::S_CLR:
            begin
                st_we = 1'b1;
                en_we = 1'b1;
                waddr = clr_cnt_reg;
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    // read address: offset entries back from the current index
    assign ch_ok   = (ch_reg < 3'(NUM_CHANNELS));
    assign off_ok  = (off_reg < 8'(LOG_DEPTH));
    assign off_low = off_reg[IW-1:0];
    assign rd_sum  = {1'b0, cur_wi} + (IW+1)'(LOG_DEPTH) - {1'b0, off_low};
    assign rd_idx  = (cur_wi >= off_low) ? (cur_wi - off_low) : rd_sum[IW-1:0];
    assign raddr   = base_addr + AW'(rd_idx);
    assign mem_re  = (state_reg == qel_pkg::S_RADR) && ch_ok && off_ok;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[waddr] <= st_wd;
        end
        if (en_we)
        begin
            en_mem[waddr] <= en_wd;
        end
        if (mem_re)
        begin
            st_rd_reg <= st_mem[raddr];
            en_rd_reg <= en_mem[raddr];
        end
    end

    assign clr_all = accept && (s_tuser == qel_pkg::REQ_CLEAR);

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                status_reg[i] <= qel_pkg::ST_IDLE;
                hold_reg[i]   <= '0;
                wi_reg[i]     <= '0;
                done_reg[i]   <= '0;
            end
        end
        else if (clr_all)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                status_reg[i] <= qel_pkg::ST_IDLE;
                hold_reg[i]   <= '0;
                wi_reg[i]     <= '0;
                done_reg[i]   <= '0;
            end
        end
        else if (state_reg == qel_pkg::S_UPD)
        begin
            status_reg[cnt_reg] <= status_next;
            hold_reg[cnt_reg]   <= hold_next;
            wi_reg[cnt_reg]     <= wi_next;
            done_reg[cnt_reg]   <= done_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_hold_reg <= 8'd1;
            end_hold_reg   <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qel_pkg::CFG_START_HOLD: start_hold_reg <= cfg_data;
                qel_pkg::CFG_END_HOLD:   end_hold_reg   <= cfg_data;
                default:                 start_hold_reg <= start_hold_reg;
            endcase
        end
    end

    // latched item fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bits_reg <= {s_tdata[5:3], s_tdata[2:0]};
            ts_reg   <= s_tdata[14 +: TIME_BITS];
            ch_reg   <= s_tdata[48:46];
            off_reg  <= s_tdata[56:49];
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= qel_pkg::S_CLR;
            cnt_reg         <= '0;
            clr_cnt_reg     <= '0;
            clr_reply_reg   <= 1'b0;
            changed_reg     <= 1'b0;
            flag_copy_reg   <= '0;
            res_ok_reg      <= 1'b0;
            res_changed_reg <= 1'b0;
            res_count_reg   <= '0;
            res_start_reg   <= '0;
            res_end_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= '0;
        end
        else
        begin
            // the wait state reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != qel_pkg::S_WAIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                qel_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        res_ok_reg      <= 1'b0;
                        res_changed_reg <= 1'b0;
                        res_count_reg   <= '0;
                        res_start_reg   <= '0;
                        res_end_reg     <= '0;
                        cnt_reg         <= '0;
                        changed_reg     <= 1'b0;
                        unique case (s_tuser)
                            qel_pkg::REQ_UPDATE:
                            begin
                                flag_copy_reg <= {s_tdata[5:3], s_tdata[2:0], s_tdata[13:6]};
                                state_reg     <= qel_pkg::S_UPD;
                            end
                            qel_pkg::REQ_READ:
                            begin
                                state_reg <= qel_pkg::S_RADR;
                            end
                            qel_pkg::REQ_CLEAR:
                            begin
                                clr_cnt_reg   <= '0;
                                clr_reply_reg <= 1'b1;
                                state_reg     <= qel_pkg::S_CLR;
                            end
                            default:
                            begin
                                // unknown kind: no state change, rejected
                                state_reg <= qel_pkg::S_WAIT;
                            end
                        endcase
                    end
                end
                qel_pkg::S_UPD:
                begin
                    if (ended)
                    begin
                        changed_reg <= 1'b1;
                        state_reg   <= qel_pkg::S_UPD2;
                    end
                    else if (last_ch)
                    begin
                        res_ok_reg      <= 1'b1;
                        res_changed_reg <= changed_reg;
                        state_reg       <= qel_pkg::S_WAIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                qel_pkg::S_UPD2:
                begin
                    if (last_ch)
                    begin
                        res_ok_reg      <= 1'b1;
                        res_changed_reg <= changed_reg;
                        state_reg       <= qel_pkg::S_WAIT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CW'(1);
                        state_reg <= qel_pkg::S_UPD;
                    end
                end
                qel_pkg::S_RADR:
                begin
                    if (ch_ok)
                    begin
                        res_count_reg <= cur_done;
                    end
                    if (ch_ok && off_ok)
                    begin
                        state_reg <= qel_pkg::S_RDAT;
                    end
                    else
                    begin
                        state_reg <= qel_pkg::S_WAIT;
                    end
                end
                qel_pkg::S_RDAT:
                begin
                    res_ok_reg    <= 1'b1;
                    res_start_reg <= st_rd_reg;
                    res_end_reg   <= en_rd_reg;
                    state_reg     <= qel_pkg::S_WAIT;
                end
                qel_pkg::S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH_ALL - 1))
                    begin
                        // the sweep after reset gives no result
                        if (clr_reply_reg)
                        begin
                            res_ok_reg <= 1'b1;
                            state_reg  <= qel_pkg::S_WAIT;
                        end
                        else
                        begin
                            state_reg <= qel_pkg::S_IDLE;
                        end
                    end
                end
                qel_pkg::S_WAIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, flag_copy_reg,
                                         qel_pkg::FIELD_TIME_W'(res_end_reg),
                                         qel_pkg::FIELD_TIME_W'(res_start_reg),
                                         res_count_reg};
                        m_tuser_reg  <= {res_changed_reg, res_ok_reg};
                        state_reg    <= qel_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= qel_pkg::S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    // an item keeps the block busy for at least the next cycle
    `QEL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !s_tready)
    // a logged end is always followed by zeroing the next ring entry
    `QEL_ASSERT_NEXT(a_upd2_after_end, clk, rst_n,
        (state_reg == qel_pkg::S_UPD) && ended, state_reg == qel_pkg::S_UPD2)
    // a new result is only handed over from the wait state
    `QEL_ASSERT_SAME(a_load_from_wait, clk, rst_n,
        $rose(m_tvalid_reg), $past(state_reg == qel_pkg::S_WAIT))
    // the ring index of the walked channel stays inside the ring
    `QEL_ASSERT_SAME(a_index_in_ring, clk, rst_n,
        state_reg == qel_pkg::S_UPD, cur_wi < IW'(LOG_DEPTH - 1) || cur_wi == IW'(LOG_DEPTH - 1))

endmodule
